// ===== design/swms_pkg.sv =====
package swms_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_WRITE_COEFF  = 2'd0;
  localparam logic [1:0] OP_WRITE_SENSOR = 2'd1;
  localparam logic [1:0] OP_SET_STATE    = 2'd2;
  localparam logic [1:0] OP_STEP         = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_BAD_TOTAL = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] CFG_STATE_COUNT  = 8'd0;
  localparam logic [7:0] CFG_SENSOR_COUNT = 8'd1;

  // Weight and total accumulator width, enough for 64 states of 32 sensors
  localparam int ACC_W = 40;
  localparam int LHS_W = ACC_W + 17;

  typedef struct packed {
    logic       load;        // latch the accepted item
    logic       coeff_we;    // write coefficient of the latched item
    logic       sensor_we;   // write sensor of the latched item
    logic       set_state;   // force state to to_state
    logic       clear_total; // start of a step
    logic       scan_valid;  // issue one coefficient read
    logic [4:0] t;           // candidate state
    logic [3:0] k;           // coefficient within the row
    logic       mul;         // form random * total
    logic       clear_run;   // reset running sum
    logic       pick_rd;     // read weight t
    logic       run_add;     // add weight t to running sum
    logic       pick_state;  // take t as next state
    logic       out_load;    // capture result
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       coeff_ok;
    logic       sensor_ok;
    logic       state_ok;
    logic [4:0] ns;
    logic [3:0] nk;
    logic       pipe_busy;
    logic       total_pos;
    logic       hit;
  } stat_t;

endpackage

// ===== design/swms_ram.sv =====
module swms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/swms_ctrl.sv =====
module swms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  swms_pkg::stat_t stat,
  output swms_pkg::cmd_t  cmd
);
  import swms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_DRAIN, S_MUL, S_PICK_RD, S_PICK_CMP, S_FINISH
  } state_t;

  state_t     state;
  logic [4:0] t;
  logic [3:0] k;
  logic [1:0] res_status;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.t          = t;
    cmd.k          = k;
    cmd.out_status = res_status;
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_EXEC: begin
        unique case (stat.op)
          OP_WRITE_COEFF:  cmd.coeff_we  = stat.coeff_ok;
          OP_WRITE_SENSOR: cmd.sensor_we = stat.sensor_ok;
          OP_SET_STATE:    cmd.set_state = stat.state_ok;
          OP_STEP:         cmd.clear_total = 1'b1;
          default:         cmd.clear_total = 1'b0;
        endcase
      end
      S_SCAN:     cmd.scan_valid = 1'b1;
      S_DRAIN:    cmd.clear_run  = 1'b0;
      S_MUL: begin
        cmd.mul       = 1'b1;
        cmd.clear_run = 1'b1;
      end
      S_PICK_RD:  cmd.pick_rd = 1'b1;
      S_PICK_CMP: begin
        cmd.run_add    = 1'b1;
        cmd.pick_state = stat.hit;
      end
      S_FINISH:   cmd.out_load = out_free;
      default:    cmd.out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      t          <= '0;
      k          <= '0;
      res_status <= ST_OK;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          t          <= '0;
          k          <= '0;
          res_status <= ST_OK;
          unique case (stat.op)
            OP_WRITE_COEFF: begin
              if (!stat.coeff_ok) res_status <= ST_BAD_INDEX;
              state <= S_FINISH;
            end
            OP_WRITE_SENSOR: begin
              if (!stat.sensor_ok) res_status <= ST_BAD_INDEX;
              state <= S_FINISH;
            end
            OP_SET_STATE: begin
              if (!stat.state_ok) res_status <= ST_BAD_INDEX;
              state <= S_FINISH;
            end
            default: state <= S_SCAN;
          endcase
        end
        S_SCAN: begin
          // walk the row: every coefficient of candidate t, then the next t
          if (k == stat.nk) begin
            k <= '0;
            if (t == stat.ns - 5'd1) begin
              state <= S_DRAIN;
            end else begin
              t <= t + 5'd1;
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            if (stat.total_pos) begin
              state <= S_MUL;
            end else begin
              res_status <= ST_BAD_TOTAL;
              state      <= S_FINISH;
            end
          end
        end
        S_MUL: begin
          t     <= '0;
          state <= S_PICK_RD;
        end
        S_PICK_RD: state <= S_PICK_CMP;
        S_PICK_CMP: begin
          priority if (stat.hit || t == stat.ns - 5'd1) begin
            state <= S_FINISH;
          end else begin
            t     <= t + 5'd1;
            state <= S_PICK_RD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/swms_dp.sv =====
module swms_dp #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SENSORS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         operation,
  input  logic [3:0]         from_state,
  input  logic [3:0]         to_state,
  input  logic [3:0]         coeff_index,
  input  logic [2:0]         sensor_index,
  input  logic signed [15:0] value,
  input  logic [15:0]        random_fraction,
  input  swms_pkg::cmd_t     cmd,
  output swms_pkg::stat_t    stat,
  output logic [3:0]         current_state,
  output logic [1:0]         status
);
  import swms_pkg::*;

  localparam int ROW_LEN = MAX_SENSORS + 1;
  localparam int CDEPTH  = MAX_STATES * MAX_STATES * ROW_LEN;
  localparam int CAW     = $clog2(CDEPTH);
  localparam int WAW     = $clog2(MAX_STATES);

  logic [4:0] state_count;
  logic [3:0] sensor_count;
  logic [4:0] ns;
  logic [3:0] nk;

  // latched item
  logic [1:0]         op_q;
  logic [3:0]         from_q;
  logic [3:0]         to_q;
  logic [3:0]         ci_q;
  logic [2:0]         si_q;
  logic signed [15:0] val_q;
  logic [15:0]        rnd_q;

  logic signed [15:0] sensors [MAX_SENSORS];
  logic [4:0]         cur;

  // scan pipeline
  logic                     v1, f1, l1, v2, f2, l2, v3;
  logic [4:0]               t1, t2, t3;
  logic signed [15:0]       sens_q;
  logic signed [15:0]       sens_sel;
  logic signed [31:0]       prod2;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  total;

  logic [CAW-1:0]           coeff_waddr, coeff_raddr;
  logic [15:0]              coeff_rdata;
  logic [ACC_W-1:0]         w_rdata;

  logic signed [LHS_W-1:0]  lhs;
  logic signed [ACC_W-1:0]  run;
  logic signed [ACC_W-1:0]  run_next;
  logic signed [LHS_W-1:0]  run_sh;

  always_comb begin
    if (state_count == 5'd0) begin
      ns = 5'd1;
    end else if (32'(state_count) > MAX_STATES) begin
      ns = 5'(MAX_STATES);
    end else begin
      ns = state_count;
    end
    nk = (32'(sensor_count) > MAX_SENSORS) ? 4'(MAX_SENSORS) : sensor_count;
  end

  assign coeff_waddr = CAW'((32'(from_q) * MAX_STATES + 32'(to_q)) * ROW_LEN + 32'(ci_q));
  assign coeff_raddr = CAW'((32'(cur) * MAX_STATES + 32'(cmd.t)) * ROW_LEN + 32'(cmd.k));

  always_comb begin
    // base weight goes through the multiplier as base * 1.0
    sens_sel = 16'sd256;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      if (32'(cmd.k) == i + 1) sens_sel = sensors[i];
    end
  end

  assign term     = ACC_W'(prod2 >>> 8);
  assign run_next = run + $signed(w_rdata);
  assign run_sh   = {run_next[ACC_W-1], run_next, 16'b0};

  assign stat.op        = op_q;
  assign stat.coeff_ok  = ({1'b0, from_q} < ns) && ({1'b0, to_q} < ns) && (ci_q <= nk);
  assign stat.sensor_ok = ({1'b0, si_q} < nk);
  assign stat.state_ok  = ({1'b0, to_q} < ns);
  assign stat.ns        = ns;
  assign stat.nk        = nk;
  assign stat.pipe_busy = v1 || v2 || v3;
  assign stat.total_pos = (total > 0);
  assign stat.hit       = (lhs <= run_sh);

  swms_ram #(.WIDTH(16), .DEPTH(CDEPTH)) u_coeff_ram (
    .clk   (clk),
    .we    (cmd.coeff_we),
    .waddr (coeff_waddr),
    .wdata (val_q),
    .raddr (coeff_raddr),
    .rdata (coeff_rdata)
  );

  swms_ram #(.WIDTH(ACC_W), .DEPTH(MAX_STATES)) u_weight_ram (
    .clk   (clk),
    .we    (v3),
    .waddr (WAW'(t3)),
    .wdata (acc),
    .raddr (WAW'(cmd.t)),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= 5'd16;
      sensor_count <= 4'd0;
      cur <= '0;
      for (int i = 0; i < MAX_SENSORS; i++) sensors[i] <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_STATE_COUNT) state_count <= cfg_data[4:0];
        if (cfg_index == CFG_SENSOR_COUNT) sensor_count <= cfg_data[3:0];
      end
      if (cmd.sensor_we) begin
        for (int i = 0; i < MAX_SENSORS; i++) begin
          if (32'(si_q) == i) sensors[i] <= val_q;
        end
      end
      if (cmd.set_state) cur <= {1'b0, to_q};
      if (cmd.pick_state) cur <= cmd.t;
      v1 <= cmd.scan_valid;
      v2 <= v1;
      v3 <= v2 && l2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      from_q <= from_state;
      to_q   <= to_state;
      ci_q   <= coeff_index;
      si_q   <= sensor_index;
      val_q  <= value;
      rnd_q  <= random_fraction;
    end
    f1     <= (cmd.k == 4'd0);
    l1     <= (cmd.k == nk);
    t1     <= cmd.t;
    sens_q <= sens_sel;
    prod2  <= $signed(coeff_rdata) * sens_q;
    f2     <= f1;
    l2     <= l1;
    t2     <= t1;
    if (v2) acc <= f2 ? term : acc + term;
    t3     <= t2;
    if (cmd.clear_total) begin
      total <= '0;
    end else if (v3) begin
      total <= total + acc;
    end
    if (cmd.mul) lhs <= $signed({1'b0, rnd_q}) * total;
    if (cmd.clear_run) begin
      run <= '0;
    end else if (cmd.run_add) begin
      run <= run_next;
    end
    if (cmd.out_load) begin
      current_state <= cur[3:0];
      status        <= cmd.out_status;
    end
  end

endmodule

// ===== design/sensor_weighted_markov_step.sv =====
// Sensor-weighted Markov step. Write items load coefficients (op 0) and
// sensor values (op 1) or force the state (op 2); a step item (op 3) draws
// the next state by roulette-wheel selection over weights
// base + sum(coeff * sensor) of the current row, in signed Q8.8, and each
// item returns one result: the state after the item and a status (0 ok,
// 1 index out of range, 2 total weight not positive, state kept). Items are
// taken one at a time. A step streams the row's coefficients through one
// read port of the coefficient RAM and one multiplier at one coefficient a
// cycle, drains the 3-stage multiply pipeline, then scans the stored
// weights, reading each one and then comparing it; a step whose total is
// not positive skips the draw. A stalled output delays the end of the item.
// A finished result waits in an output register while the next item is
// accepted. Coefficients read before being written return arbitrary weights.
// Configuration: index 0 state_count, index 1 sensor_count; write only while
// the block is idle.
module sensor_weighted_markov_step #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SENSORS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [3:0]         from_state,
  input  logic [3:0]         to_state,
  input  logic [3:0]         coeff_index,
  input  logic [2:0]         sensor_index,
  input  logic signed [15:0] value,
  input  logic [15:0]        random_fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         current_state,
  output logic [1:0]         status
);
  import swms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequence each item: decode, row scan, drain, draw, deliver
  swms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold tables, weights, state and the result register
  swms_dp #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SENSORS (MAX_SENSORS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .from_state      (from_state),
    .to_state        (to_state),
    .coeff_index     (coeff_index),
    .sensor_index    (sensor_index),
    .value           (value),
    .random_fraction (random_fraction),
    .cmd             (cmd),
    .stat            (stat),
    .current_state   (current_state),
    .status          (status)
  );

endmodule
